// ===== design/cacn_pkg.sv =====
// ----------------------------------------------------------------------------
// cacn_pkg
// Shared widths, character codes and the binary-to-BCD step used by the
// uppercase amount converter.
// ----------------------------------------------------------------------------
package cacn_pkg;

    localparam int BIN_W    = 40;
    localparam int NDIG     = 12;
    localparam int BCD_W    = NDIG * 4;
    localparam int CODE_W   = 5;
    localparam int NSTAGE   = 6;                 // input stage plus one per byte
    localparam int NSLOT    = 42;                // candidate character slots
    localparam int SLOT_W   = $clog2(NSLOT);

    localparam logic [BIN_W-1:0] LIMIT_CENTS = 40'd1000000000000;

    localparam logic [CODE_W-1:0] CODE_ZERO  = 5'd0;
    localparam logic [CODE_W-1:0] CODE_SHI   = 5'd10;
    localparam logic [CODE_W-1:0] CODE_BAI   = 5'd11;
    localparam logic [CODE_W-1:0] CODE_QIAN  = 5'd12;
    localparam logic [CODE_W-1:0] CODE_WAN   = 5'd13;
    localparam logic [CODE_W-1:0] CODE_YI    = 5'd14;
    localparam logic [CODE_W-1:0] CODE_YUAN  = 5'd15;
    localparam logic [CODE_W-1:0] CODE_JIAO  = 5'd16;
    localparam logic [CODE_W-1:0] CODE_FEN   = 5'd17;
    localparam logic [CODE_W-1:0] CODE_ZHENG = 5'd18;

    // Unit character after a nonzero digit, by position inside a group
    function automatic logic [CODE_W-1:0] unit_of_pos(input logic [1:0] pos);
        logic [CODE_W-1:0] u;
        begin
            case (pos)
                2'd1:    u = CODE_SHI;
                2'd2:    u = CODE_BAI;
                2'd3:    u = CODE_QIAN;
                default: u = CODE_ZERO;
            endcase
            return u;
        end
    endfunction

    // Eight shift-add-3 steps: folds one input byte, MSB first, into the BCD
    function automatic logic [BCD_W-1:0] dabble8(input logic [BCD_W-1:0] bcd_in,
                                                 input logic [7:0] byte_in);
        logic [BCD_W-1:0] b;
        begin
            b = bcd_in;
            for (int j = 7; j >= 0; j--)
            begin
                for (int d = 0; d < NDIG; d++)
                begin
                    if (b[4*d +: 4] >= 4'd5)
                        b[4*d +: 4] = b[4*d +: 4] + 4'd3;
                end
                b = {b[BCD_W-2:0], byte_in[j]};
            end
            return b;
        end
    endfunction

endpackage

// ===== design/currency_amount_to_chinese_numerals.sv =====
// ----------------------------------------------------------------------------
// currency_amount_to_chinese_numerals
// Converts an amount in cents to its uppercase financial wording, one
// character code per output word, with a last mark on the final one.
// ----------------------------------------------------------------------------
// An amount word enters whenever in_ready is high; amounts may follow each
// other every cycle while in_ready stays high. The amount is registered,
// converted to twelve decimal digits over five byte-wide BCD stages, laid out
// as a fixed list of candidate character slots in one more stage, and then
// drained one character per cycle, while out_ready allows, from the lowest
// live slot through the serializer and the output register. An amount has
// 1 to 24 characters (typically 3 to 20), and the single character output
// port sets the sustained rate. Amounts of 1000000000000 cents or more give
// one word with out_of_range set, char_code 0 and last set.
module currency_amount_to_chinese_numerals
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [cacn_pkg::BIN_W-1:0]           amount_cents,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [cacn_pkg::CODE_W-1:0]          char_code,
    output logic                                 last,
    output logic                                 out_of_range
);

    // Conversion pipeline stages
    logic [cacn_pkg::NSTAGE-1:0]       vld_reg;
    logic [cacn_pkg::BIN_W-1:0]        bin_reg [cacn_pkg::NSTAGE];
    logic [cacn_pkg::BCD_W-1:0]        bcd_reg [cacn_pkg::NSTAGE];
    logic [cacn_pkg::NSTAGE-1:0]       oor_reg;
    logic [cacn_pkg::NSTAGE:0]         rdy;

    // Slot stage
    logic                              tok_valid_reg;
    logic [cacn_pkg::NSLOT-1:0]        tok_mask_reg;
    logic [cacn_pkg::CODE_W-1:0]       tok_code_reg [cacn_pkg::NSLOT];
    logic                              tok_oor_reg;
    logic [cacn_pkg::NSLOT-1:0]        tok_mask_next;
    logic [cacn_pkg::CODE_W-1:0]       tok_code_next [cacn_pkg::NSLOT];

    // Serializer
    logic [cacn_pkg::NSLOT-1:0]        ser_mask_reg;
    logic [cacn_pkg::CODE_W-1:0]       ser_code_reg [cacn_pkg::NSLOT];
    logic                              ser_oor_reg;
    logic [cacn_pkg::NSLOT-1:0]        pick_hot;
    logic [cacn_pkg::CODE_W-1:0]       pick_code;
    logic                              pick_last;
    logic                              pick;
    logic                              ser_load;

    // Output register
    logic                              out_valid_reg;
    logic [cacn_pkg::CODE_W-1:0]       char_code_reg;
    logic                              last_reg;
    logic                              out_of_range_reg;

    // Ready chain: a stage moves when empty or when the next one moves
    always_comb
    begin
        rdy[cacn_pkg::NSTAGE] = !tok_valid_reg || ser_load;
        for (int k = cacn_pkg::NSTAGE - 1; k >= 0; k--)
            rdy[k] = !vld_reg[k] || rdy[k+1];
    end
    assign in_ready = rdy[0];

    // Stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (rdy[0])
                vld_reg[0] <= in_valid;
            for (int k = 1; k < cacn_pkg::NSTAGE; k++)
            begin
                if (rdy[k])
                    vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // Stage payloads: capture, then one byte of double dabble per stage
    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            bin_reg[0] <= amount_cents;
            bcd_reg[0] <= '0;
            oor_reg[0] <= (amount_cents >= cacn_pkg::LIMIT_CENTS);
        end
        for (int k = 1; k < cacn_pkg::NSTAGE; k++)
        begin
            if (rdy[k])
            begin
                bin_reg[k] <= {bin_reg[k-1][cacn_pkg::BIN_W-9:0], 8'd0};
                bcd_reg[k] <= cacn_pkg::dabble8(bcd_reg[k-1],
                                  bin_reg[k-1][cacn_pkg::BIN_W-1 -: 8]);
                oor_reg[k] <= oor_reg[k-1];
            end
        end
    end

    // Candidate character slots, in emission order
    always_comb
    begin
        logic [cacn_pkg::BCD_W-1:0] b;
        logic [3:0]                 dg;
        logic [3:0]                 dlow;
        logic                       hi_any;
        logic                       grp_any;
        logic                       ynz;
        logic                       jnz;
        logic                       fnz;
        logic [3:0]                 jd;
        logic [3:0]                 fd;
        int                         i;
        b       = bcd_reg[cacn_pkg::NSTAGE-1];
        hi_any  = 1'b0;
        grp_any = 1'b0;
        i       = 0;
        fd      = b[3:0];
        jd      = b[7:4];
        fnz     = (fd != 4'd0);
        jnz     = (jd != 4'd0);
        ynz     = (b[cacn_pkg::BCD_W-1:8] != '0);
        for (int s = 0; s < cacn_pkg::NSLOT; s++)
        begin
            tok_code_next[s] = cacn_pkg::CODE_ZERO;
            tok_mask_next[s] = 1'b0;
        end
        for (int p = 9; p >= 0; p--)
        begin
            dg   = b[4*p+8 +: 4];
            dlow = (p > 0) ? b[4*p+4 +: 4] : 4'd0;
            tok_code_next[i] = {1'b0, dg};
            tok_mask_next[i] = (dg != 4'd0);
            i++;
            tok_code_next[i] = cacn_pkg::unit_of_pos(2'(p));
            tok_mask_next[i] = (dg != 4'd0) && (p % 4 != 0);
            i++;
            tok_code_next[i] = cacn_pkg::CODE_ZERO;
            tok_mask_next[i] = (dg == 4'd0) && (p % 4 != 0) && hi_any && (dlow != 4'd0);
            i++;
            hi_any  = hi_any || (dg != 4'd0);
            grp_any = grp_any || (dg != 4'd0);
            if (p == 8 || p == 4)
            begin
                tok_code_next[i] = (p == 8) ? cacn_pkg::CODE_YI : cacn_pkg::CODE_WAN;
                tok_mask_next[i] = grp_any;
                grp_any = 1'b0;
                i++;
            end
        end
        // Tail: yuan mark, jiao and fen
        tok_code_next[i] = cacn_pkg::CODE_YUAN;  tok_mask_next[i] = ynz;                i++;
        tok_code_next[i] = cacn_pkg::CODE_ZERO;  tok_mask_next[i] = !ynz && !jnz && !fnz; i++;
        tok_code_next[i] = cacn_pkg::CODE_YUAN;  tok_mask_next[i] = !ynz && !jnz && !fnz; i++;
        tok_code_next[i] = cacn_pkg::CODE_ZHENG; tok_mask_next[i] = !jnz && !fnz;       i++;
        tok_code_next[i] = {1'b0, jd};           tok_mask_next[i] = jnz;                i++;
        tok_code_next[i] = cacn_pkg::CODE_JIAO;  tok_mask_next[i] = jnz;                i++;
        tok_code_next[i] = cacn_pkg::CODE_ZHENG; tok_mask_next[i] = jnz && !fnz;        i++;
        tok_code_next[i] = cacn_pkg::CODE_ZERO;  tok_mask_next[i] = fnz && !jnz && ynz; i++;
        tok_code_next[i] = {1'b0, fd};           tok_mask_next[i] = fnz;                i++;
        tok_code_next[i] = cacn_pkg::CODE_FEN;   tok_mask_next[i] = fnz;
        // Flagged amount: one zero word
        if (oor_reg[cacn_pkg::NSTAGE-1])
        begin
            tok_mask_next    = '0;
            tok_mask_next[0] = 1'b1;
            tok_code_next[0] = cacn_pkg::CODE_ZERO;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tok_valid_reg <= 1'b0;
        else if (rdy[cacn_pkg::NSTAGE])
            tok_valid_reg <= vld_reg[cacn_pkg::NSTAGE-1];
    end

    always_ff @(posedge clk)
    begin
        if (rdy[cacn_pkg::NSTAGE])
        begin
            tok_mask_reg <= tok_mask_next;
            tok_code_reg <= tok_code_next;
            tok_oor_reg  <= oor_reg[cacn_pkg::NSTAGE-1];
        end
    end

    // Lowest live slot, as a one-hot select
    always_comb
    begin
        logic found;
        found    = 1'b0;
        pick_hot = '0;
        for (int s = 0; s < cacn_pkg::NSLOT; s++)
        begin
            if (!found && ser_mask_reg[s])
            begin
                pick_hot[s] = 1'b1;
                found       = 1'b1;
            end
        end
    end

    always_comb
    begin
        pick_code = '0;
        for (int s = 0; s < cacn_pkg::NSLOT; s++)
            pick_code = pick_code | (pick_hot[s] ? ser_code_reg[s] : '0);
    end

    assign pick_last = ((ser_mask_reg & ~pick_hot) == '0);
    assign pick      = (ser_mask_reg != '0) && (!out_valid_reg || out_ready);
    assign ser_load  = tok_valid_reg && ((ser_mask_reg == '0) || (pick && pick_last));

    // Serializer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ser_mask_reg <= '0;
        else if (ser_load)
            ser_mask_reg <= tok_mask_reg;
        else if (pick)
            ser_mask_reg <= ser_mask_reg & ~pick_hot;
    end

    always_ff @(posedge clk)
    begin
        if (ser_load)
        begin
            ser_code_reg <= tok_code_reg;
            ser_oor_reg  <= tok_oor_reg;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (pick)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pick)
        begin
            char_code_reg    <= pick_code;
            last_reg         <= pick_last;
            out_of_range_reg <= ser_oor_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign char_code    = char_code_reg;
    assign last         = last_reg;
    assign out_of_range = out_of_range_reg;

`ifndef ASSERT_OFF
    // A flagged word is always a lone zero word
    a_oor_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_of_range |-> last && (char_code == cacn_pkg::CODE_ZERO))
        else $error("flagged word is not a lone zero");

    // Every loaded amount has between 1 and 24 characters
    a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
        ser_load |-> ($countones(tok_mask_reg) >= 1) && ($countones(tok_mask_reg) <= 24))
        else $error("character run length out of bounds");

    // Pick select is one-hot whenever slots remain
    a_pick_hot: assert property (@(posedge clk) disable iff (!rst_n)
        (ser_mask_reg != '0) |-> $onehot(pick_hot))
        else $error("slot select not one-hot");

    // Serializer reloads only when its run is spent
    a_reload: assert property (@(posedge clk) disable iff (!rst_n)
        ser_load && (ser_mask_reg != '0) |-> pick && pick_last)
        else $error("serializer reloaded mid-run");
`endif

endmodule

// ===== tb/sv/tb_currency_amount_to_chinese_numerals.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_currency_amount_to_chinese_numerals
// Self-checking bench for the uppercase amount converter: a directed table
// of edge amounts, then random amounts, each word predicted in the bench and
// compared in order against the character stream with random stalls.
// ----------------------------------------------------------------------------
module tb_currency_amount_to_chinese_numerals;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int N_RANDOM       = 260;

    typedef struct packed {
        logic [cacn_pkg::CODE_W-1:0] code;
        logic                        lst;
        logic                        oor;
    } char_word_t;

    typedef struct {
        logic [cacn_pkg::BIN_W-1:0]  amount;
        int                          n_fixed;      // 0: use predictor only
        logic [cacn_pkg::CODE_W-1:0] fixed [4];
    } dir_row_t;

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_ready;
    logic [cacn_pkg::BIN_W-1:0]    amount_cents;
    logic                          out_valid;
    logic                          out_ready;
    logic [cacn_pkg::CODE_W-1:0]   char_code;
    logic                          last;
    logic                          out_of_range;

    char_word_t          expected_chars [$];
    int                  mismatch_count;
    int                  chars_seen;
    int                  amounts_sent;
    int                  oor_sent;
    int                  idle_cycles;
    bit                  no_idle;
    bit                  timed_out;

    currency_amount_to_chinese_numerals dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .amount_cents (amount_cents),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .char_code    (char_code),
        .last         (last),
        .out_of_range (out_of_range)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Predict the character run of one amount and queue it
    task automatic queue_wording(input logic [cacn_pkg::BIN_W-1:0] cents);
        logic [cacn_pkg::CODE_W-1:0] run [$];
        logic [3:0]        digit [10];
        logic [63:0]       yuan;
        logic [63:0]       rest;
        logic [3:0]        jiao;
        logic [3:0]        fen;
        bit                seen_nonzero;
        bit                group_live;
        char_word_t        w;
        if (cents >= cacn_pkg::LIMIT_CENTS)
        begin
            w.code = cacn_pkg::CODE_ZERO;
            w.lst  = 1'b1;
            w.oor  = 1'b1;
            expected_chars.push_back(w);
            return;
        end
        yuan = 64'(cents / 100);
        jiao = 4'((cents / 10) % 10);
        fen  = 4'(cents % 10);
        rest = yuan;
        for (int p = 0; p < 10; p++)
        begin
            digit[p] = 4'(rest % 10);
            rest = rest / 10;
        end
        seen_nonzero = 0;
        group_live   = 0;
        for (int p = 9; p >= 0; p--)
        begin
            if (digit[p] != 0)
            begin
                run.push_back({1'b0, digit[p]});
                if ((p % 4) != 0)
                    run.push_back(cacn_pkg::unit_of_pos(2'(p % 4)));
                seen_nonzero = 1;
                group_live   = 1;
            end
            else if (seen_nonzero && (p % 4) != 0 && p > 0 && digit[p-1] != 0)
            begin
                run.push_back(cacn_pkg::CODE_ZERO);
                seen_nonzero = 0;
            end
            if (p == 8 || p == 4)
            begin
                if (group_live)
                    run.push_back(p == 8 ? cacn_pkg::CODE_YI : cacn_pkg::CODE_WAN);
                group_live = 0;
            end
        end
        if (yuan != 0)
            run.push_back(cacn_pkg::CODE_YUAN);
        if (jiao == 0 && fen == 0)
        begin
            if (yuan == 0)
            begin
                run.push_back(cacn_pkg::CODE_ZERO);
                run.push_back(cacn_pkg::CODE_YUAN);
            end
            run.push_back(cacn_pkg::CODE_ZHENG);
        end
        if (jiao != 0)
        begin
            run.push_back({1'b0, jiao});
            run.push_back(cacn_pkg::CODE_JIAO);
            if (fen == 0)
                run.push_back(cacn_pkg::CODE_ZHENG);
        end
        if (fen != 0)
        begin
            if (jiao == 0 && yuan != 0)
                run.push_back(cacn_pkg::CODE_ZERO);
            run.push_back({1'b0, fen});
            run.push_back(cacn_pkg::CODE_FEN);
        end
        foreach (run[k])
        begin
            w.code = run[k];
            w.lst  = (k == run.size() - 1);
            w.oor  = 1'b0;
            expected_chars.push_back(w);
        end
    endtask

    // Drive one amount word and hold it until taken
    task automatic send_amount(input logic [cacn_pkg::BIN_W-1:0] cents);
        while (!no_idle && $urandom_range(99) < 27)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        amount_cents <= cents;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        amounts_sent++;
        if (cents >= cacn_pkg::LIMIT_CENTS)
            oor_sent++;
    endtask

    // Random amount, mostly in range, with varied magnitudes and zero runs
    function automatic logic [cacn_pkg::BIN_W-1:0] random_amount();
        logic [cacn_pkg::BIN_W-1:0] a;
        int               sel;
        sel = $urandom_range(99);
        if (sel < 6)
            a = 40'({$urandom, $urandom});
        else if (sel < 10)
            a = cacn_pkg::LIMIT_CENTS + 40'($urandom_range(1000));
        else
        begin
            a = '0;
            for (int d = 0; d < 12; d++)
            begin
                // sparse digits give long zero runs inside groups
                a = a * 40'd10 + 40'(($urandom_range(99) < 45) ? 0 : $urandom_range(9));
            end
            if ($urandom_range(3) == 0)
                a = a % (40'd1 << $urandom_range(34));
        end
        return a;
    endfunction

    // Result checker
    always @(posedge clk)
    begin
        char_word_t exp_w;
        if (rst_n && out_valid && out_ready)
        begin
            chars_seen++;
            if (expected_chars.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected word: code=%0d last=%0b oor=%0b",
                             char_code, last, out_of_range);
            end
            else
            begin
                exp_w = expected_chars.pop_front();
                if (char_code !== exp_w.code || last !== exp_w.lst
                    || out_of_range !== exp_w.oor)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: exp code=%0d last=%0b oor=%0b, got %0d %0b %0b",
                                 exp_w.code, exp_w.lst, exp_w.oor,
                                 char_code, last, out_of_range);
                end
            end
        end
    end

    // Receiver stalls
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 27);
    end

    // Watchdog on cycles with no accepted word on either side
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out)
        begin
            timed_out = 1;
            $display("watchdog expired");
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        dir_row_t rows [$];
        dir_row_t r;
        int       drain;
        logic [cacn_pkg::BIN_W-1:0] dir_amounts [] = '{
            40'd1, 40'd10, 40'd11, 40'd100, 40'd101, 40'd110,
            40'd100000000000, 40'd999999999999, 40'd1000000000000,
            40'hFF_FFFF_FFFF, 40'd1000001, 40'd100000100, 40'd1000010000,
            40'd10010010001, 40'd500000000000, 40'd123456789012,
            40'd1000000001, 40'd90000000009, 40'd55555555555, 40'hAA_AAAA_AAAA,
            40'h55_5555_5555
        };

        in_valid       = 1'b0;
        amount_cents   = '0;
        rst_n          = 1'b0;
        mismatch_count = 0;
        chars_seen     = 0;
        amounts_sent   = 0;
        oor_sent       = 0;
        idle_cycles    = 0;
        no_idle        = 0;
        timed_out      = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: typed-in results for the obvious rows
        r.amount = 40'd0;  r.n_fixed = 3;
        r.fixed = '{cacn_pkg::CODE_ZERO, cacn_pkg::CODE_YUAN, cacn_pkg::CODE_ZHENG,
                    cacn_pkg::CODE_ZERO};
        rows.push_back(r);
        r.amount = 40'd100; r.n_fixed = 3;
        r.fixed = '{5'd1, cacn_pkg::CODE_YUAN, cacn_pkg::CODE_ZHENG, cacn_pkg::CODE_ZERO};
        rows.push_back(r);
        r.amount = 40'd5;  r.n_fixed = 2;
        r.fixed = '{5'd5, cacn_pkg::CODE_FEN, cacn_pkg::CODE_ZERO, cacn_pkg::CODE_ZERO};
        rows.push_back(r);
        r.amount = 40'd90; r.n_fixed = 3;
        r.fixed = '{5'd9, cacn_pkg::CODE_JIAO, cacn_pkg::CODE_ZHENG, cacn_pkg::CODE_ZERO};
        rows.push_back(r);
        foreach (dir_amounts[i])
        begin
            r.amount  = dir_amounts[i];
            r.n_fixed = 0;
            rows.push_back(r);
        end

        foreach (rows[i])
        begin
            if (rows[i].n_fixed == 0)
                queue_wording(rows[i].amount);
            else
                for (int k = 0; k < rows[i].n_fixed; k++)
                    expected_chars.push_back({rows[i].fixed[k],
                                              1'(k == rows[i].n_fixed - 1), 1'b0});
            send_amount(rows[i].amount);
        end
        in_valid <= 1'b0;

        // Hold the sender until the output side has drained
        while (expected_chars.size() != 0)
            @(posedge clk);

        for (int i = 0; i < N_RANDOM; i++)
        begin
            logic [cacn_pkg::BIN_W-1:0] a;
            a = random_amount();
            no_idle = (i >= 100 && i < 150);
            queue_wording(a);
            send_amount(a);
        end
        in_valid <= 1'b0;
        no_idle   = 0;

        while (expected_chars.size() != 0)
            @(posedge clk);
        drain = 0;
        while (drain < 40)
        begin
            @(posedge clk);
            drain++;
        end

        $display("sent %0d amounts (%0d out of range), checked %0d characters",
                 amounts_sent, oor_sent, chars_seen);
        if (mismatch_count == 0 && expected_chars.size() == 0)
            $display("== PASS ==");
        else
        begin
            $display("%0d mismatches", mismatch_count);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
